// ===== rtl/fsfc_pkg.sv =====
// Shared widths, codes and control types for the fader-selected FIR convolver.
package fsfc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 18;
  localparam int GAIN_W    = 16;
  localparam int LEN_W     = 11;
  localparam int CIDX_W    = 10;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int NUM_BANKS = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_SHIFT = 16;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BANK_LOW  = 2'd0,
    BANK_MID  = 2'd1,
    BANK_HIGH = 2'd2
  } bank_t;

  typedef enum logic [2:0] {
    REG_MIN_GAIN  = 3'd0,
    REG_MAX_GAIN  = 3'd1,
    REG_BANK0_LEN = 3'd2,
    REG_BANK1_LEN = 3'd3,
    REG_BANK2_LEN = 3'd4
  } reg_idx_t;

  // Controls from the tap sequencer to the multiply-accumulate datapath
  typedef struct packed {
    logic clear;
    logic issue;
    logic hist_ok;
  } mac_ctrl_t;

endpackage

// ===== rtl/fsfc_mac.sv =====
// Multiply-accumulate datapath with round-half-up and saturation to Q1.23.
module fsfc_mac
  import fsfc_pkg::*;
#(
  parameter int ACC_W = 53
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [COEF_W-1:0]   coef_q,
  input  logic signed [SAMPLE_W-1:0] hist_q,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int RS_W = ACC_W + 1 - FRAC_SHIFT;
  localparam logic signed [RS_W-1:0] SAT_HI = RS_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(-(1 << (SAMPLE_W - 1)));

  logic                       rd_v;
  logic                       rd_ok;
  logic                       pr_v;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] hist_eff;
  logic signed [ACC_W:0]      rsum;
  logic signed [RS_W-1:0]     rshift;

  // Align the control with the registered memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      rd_ok <= 1'b0;
      pr_v  <= 1'b0;
    end else begin
      rd_v  <= ctrl.issue;
      rd_ok <= ctrl.hist_ok;
      pr_v  <= rd_v;
    end
  end

  // Mask history entries not written since the last clear
  assign hist_eff = rd_ok ? hist_q : '0;

  // Register the product, then accumulate
  always_ff @(posedge clk) begin
    prod <= coef_q * hist_eff;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (pr_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = rd_v | pr_v;

  // Round half toward positive infinity, drop the fraction, saturate
  always_comb begin
    rsum   = (ACC_W + 1)'(acc) + (ACC_W + 1)'(1 << (FRAC_SHIFT - 1));
    rshift = RS_W'(rsum >>> FRAC_SHIFT);
    if (rshift > SAT_HI) begin
      result = SAT_HI[SAMPLE_W-1:0];
    end else if (rshift < SAT_LO) begin
      result = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result = rshift[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/fader_selected_fir_convolver.sv =====
// Top level: gain-selected FIR filter with per-channel circular history memory.
// Throughput: one item at a time; a filtered sample holds the block while the single
//   multiply-accumulate reads one tap per cycle from the memories.
// Reset: registers take their defaults, channel state and handshake clear at once; history reads as zero
//   through per-channel fill flags (no clearing pass); coefficients are undefined until written.
module fader_selected_fir_convolver
  import fsfc_pkg::*;
#(
  parameter int MAX_TAPS = 1024,
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic [1:0]                 channel,
  input  logic signed [GAIN_W-1:0]   fader_gain,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [1:0]                 coef_bank,
  input  logic [CIDX_W-1:0]          coef_index,
  input  logic signed [COEF_W-1:0]   coef_value,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic [1:0]                 bank_used,
  output logic                       filtered,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HDEPTH   = CHANNELS * MAX_TAPS;
  localparam int CDEPTH   = NUM_BANKS * MAX_TAPS;
  localparam int HA_W     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int CA_W     = $clog2(CDEPTH);
  localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int CI_W     = (CNT_W > CIDX_W) ? CNT_W : CIDX_W;
  localparam int ACC_W    = PROD_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SETUP,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [GAIN_W-1:0] min_gain;
  logic signed [GAIN_W-1:0] max_gain;
  logic [LEN_W-1:0]         bank_len [NUM_BANKS];

  // latched item
  logic [1:0]                 item_opcode;
  logic [1:0]                 item_channel;
  logic signed [GAIN_W-1:0]   item_gain;
  logic signed [SAMPLE_W-1:0] item_sample;
  logic [1:0]                 item_coef_bank;
  logic [CIDX_W-1:0]          item_coef_index;
  logic signed [COEF_W-1:0]   item_coef_value;

  // per-channel state
  logic [IDX_W-1:0] wpos     [CHANNELS];
  logic             full     [CHANNELS];
  bank_t            act_bank [CHANNELS];

  // sequencer registers
  bank_t            bank_r;
  logic [CNT_W-1:0] taps_r;
  logic [CNT_W-1:0] tap;
  logic [IDX_W-1:0] ridx;
  logic [IDX_W-1:0] pos_r;
  logic             full_r;

  // pending result
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_filtered;

  // memories
  logic signed [SAMPLE_W-1:0] hist_mem [HDEPTH];
  logic signed [COEF_W-1:0]   coef_mem [CDEPTH];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [COEF_W-1:0]   coef_q;

  logic [CH_IDX_W-1:0] ch_idx;
  logic                ch_ok;
  bank_t               bank_sel;
  logic [LEN_W-1:0]    len_sel;
  logic [CNT_W-1:0]    taps_sel;
  logic                bank_chg;
  logic [IDX_W-1:0]    pos_eff;
  logic                full_eff;
  logic [IDX_W-1:0]    pos_inc;
  logic                pass;
  logic                coef_ok;
  logic                coef_we;
  logic [CA_W-1:0]     coef_waddr;
  logic [CA_W-1:0]     coef_raddr;
  logic                hist_we;
  logic [HA_W-1:0]     hist_waddr;
  logic [HA_W-1:0]     hist_raddr;
  logic                cfg_we;
  reg_idx_t            cfg_idx;
  mac_ctrl_t           mac_ctrl;
  logic                mac_busy;
  logic signed [SAMPLE_W-1:0] mac_result;

  // Pick a bank by thirds of the clamped gain range
  function automatic bank_t select_bank(
    input logic signed [GAIN_W-1:0] g,
    input logic signed [GAIN_W-1:0] mn,
    input logic signed [GAIN_W-1:0] mx
  );
    logic signed [GAIN_W:0]   r;
    logic signed [GAIN_W-1:0] gc;
    logic [GAIN_W:0]          d;
    logic [GAIN_W+2:0]        d3;
    logic [GAIN_W+2:0]        r1;
    logic [GAIN_W+2:0]        r2;
    bank_t                    b;
    r  = (GAIN_W + 1)'(mx) - (GAIN_W + 1)'(mn);
    gc = (g < mn) ? mn : g;
    gc = (gc > mx) ? mx : gc;
    d  = (GAIN_W + 1)'((GAIN_W + 1)'(gc) - (GAIN_W + 1)'(mn));
    d3 = (GAIN_W + 3)'({d, 1'b0}) + (GAIN_W + 3)'(d);
    r1 = (GAIN_W + 3)'(unsigned'(r));
    r2 = (GAIN_W + 3)'({unsigned'(r), 1'b0});
    if (r <= 0) begin
      b = BANK_LOW;
    end else if (d3 < r1) begin
      b = BANK_LOW;
    end else if (d3 < r2) begin
      b = BANK_MID;
    end else begin
      b = BANK_HIGH;
    end
    return b;
  endfunction

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gain    <= GAIN_W'(-15360);
      max_gain    <= GAIN_W'(2560);
      bank_len[0] <= '0;
      bank_len[1] <= '0;
      bank_len[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MIN_GAIN:  min_gain    <= pwdata[GAIN_W-1:0];
        REG_MAX_GAIN:  max_gain    <= pwdata[GAIN_W-1:0];
        REG_BANK0_LEN: bank_len[0] <= pwdata[LEN_W-1:0];
        REG_BANK1_LEN: bank_len[1] <= pwdata[LEN_W-1:0];
        REG_BANK2_LEN: bank_len[2] <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MIN_GAIN:  prdata = DATA_W'(min_gain);
      REG_MAX_GAIN:  prdata = DATA_W'(max_gain);
      REG_BANK0_LEN: prdata = DATA_W'(bank_len[0]);
      REG_BANK1_LEN: prdata = DATA_W'(bank_len[1]);
      REG_BANK2_LEN: prdata = DATA_W'(bank_len[2]);
      default:       prdata = '0;
    endcase
  end

  // Decode: bank choice and tap count, clamped to the history depth
  always_comb begin
    bank_sel = select_bank(item_gain, min_gain, max_gain);
    case (bank_sel)
      BANK_LOW:  len_sel = bank_len[0];
      BANK_MID:  len_sel = bank_len[1];
      BANK_HIGH: len_sel = bank_len[2];
      default:   len_sel = '0;
    endcase
    if (CMP_W'(len_sel) > CMP_W'(MAX_TAPS)) begin
      taps_sel = CNT_W'(MAX_TAPS);
    end else begin
      taps_sel = CNT_W'(len_sel);
    end
  end

  // Setup: channel state after a possible bank change
  assign ch_idx   = CH_IDX_W'(item_channel);
  assign ch_ok    = 3'(item_channel) < 3'(CHANNELS);
  assign pass     = !ch_ok || (taps_r == '0);
  assign bank_chg = act_bank[ch_idx] != bank_r;
  assign pos_eff  = bank_chg ? '0 : wpos[ch_idx];
  assign full_eff = bank_chg ? 1'b0 : full[ch_idx];
  assign pos_inc  = (pos_eff == IDX_W'(MAX_TAPS - 1)) ? '0 : pos_eff + 1'b1;

  // Memory addresses and write enables
  assign coef_ok    = (item_coef_bank < 2'(NUM_BANKS)) &&
                      (CI_W'(item_coef_index) < CI_W'(MAX_TAPS));
  assign coef_we    = (state == S_DECODE) && (op_t'(item_opcode) == OP_COEF) && coef_ok;
  assign coef_waddr = CA_W'(item_coef_bank) * CA_W'(MAX_TAPS) + CA_W'(item_coef_index);
  assign coef_raddr = CA_W'(bank_r) * CA_W'(MAX_TAPS) + CA_W'(tap);
  assign hist_we    = (state == S_SETUP) && !pass;
  assign hist_waddr = HA_W'(ch_idx) * HA_W'(MAX_TAPS) + HA_W'(pos_eff);
  assign hist_raddr = HA_W'(ch_idx) * HA_W'(MAX_TAPS) + HA_W'(ridx);

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= item_coef_value;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= item_sample;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  // Tap issue toward the datapath
  always_comb begin
    mac_ctrl.clear   = (state == S_SETUP);
    mac_ctrl.issue   = (state == S_RUN);
    mac_ctrl.hist_ok = full_r || (ridx <= pos_r);
  end

  fsfc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef_q (coef_q),
    .hist_q (hist_q),
    .busy   (mac_busy),
    .result (mac_result)
  );

  assign in_stall = (state != S_IDLE);

  // Sequencer, channel state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wpos[c]     <= '0;
        full[c]     <= 1'b0;
        act_bank[c] <= BANK_MID;
      end
    end else begin
      // drop a beat the sink has taken
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_opcode     <= opcode;
            item_channel    <= channel;
            item_gain       <= fader_gain;
            item_sample     <= sample_in;
            item_coef_bank  <= coef_bank;
            item_coef_index <= coef_index;
            item_coef_value <= coef_value;
            state           <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_t'(item_opcode))
            OP_FILTER: begin
              bank_r <= bank_sel;
              taps_r <= taps_sel;
              state  <= S_SETUP;
            end
            OP_CLEAR: begin
              for (int c = 0; c < CHANNELS; c++) begin
                wpos[c] <= '0;
                full[c] <= 1'b0;
              end
              state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_SETUP: begin
          if (pass) begin
            res_sample   <= item_sample;
            res_filtered <= 1'b0;
            state        <= S_OUT;
          end else begin
            wpos[ch_idx]     <= pos_inc;
            full[ch_idx]     <= full_eff | (pos_eff == IDX_W'(MAX_TAPS - 1));
            act_bank[ch_idx] <= bank_r;
            pos_r            <= pos_eff;
            full_r           <= full_eff;
            ridx             <= pos_eff;
            tap              <= '0;
            state            <= S_RUN;
          end
        end
        S_RUN: begin
          // advance one tap back through the circular history
          tap  <= tap + 1'b1;
          ridx <= (ridx == '0) ? IDX_W'(MAX_TAPS - 1) : ridx - 1'b1;
          if (tap == taps_r - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            res_sample   <= mac_result;
            res_filtered <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            sample_out <= res_sample;
            bank_used  <= bank_r;
            filtered   <= res_filtered;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench for the fader-selected FIR convolver: directed and random beats against a scoreboard.
`timescale 1ns / 1ps

module tb;
  import fsfc_pkg::*;

  localparam int MAX_TAPS = 64;
  localparam int CHANNELS = 2;
  localparam int RUN_LEN = 57;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int PRELOAD_TAPS = 24;
  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] BANK_NONE = 2'd3;

  typedef enum {PACE_SEND_LIGHT, PACE_SEND_HEAVY, PACE_NONE} pace_t;

  typedef struct {
    logic [1:0]                 opcode;
    logic [1:0]                 channel;
    logic signed [GAIN_W-1:0]   fader_gain;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [1:0]                 coef_bank;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } beat_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [1:0]                 bank;
    logic                       filtered;
  } fir_out_t;

  // Filter predictor with its own copy of registers, coefficients and channel history
  class fir_board;
    logic signed [GAIN_W-1:0]   min_gain;
    logic signed [GAIN_W-1:0]   max_gain;
    logic [LEN_W-1:0]           bank_len [NUM_BANKS];
    logic signed [COEF_W-1:0]   coef [NUM_BANKS][MAX_TAPS];
    logic signed [SAMPLE_W-1:0] hist [CHANNELS][MAX_TAPS];
    int                         wr_pos [CHANNELS];
    bank_t                      active [CHANNELS];
    fir_out_t                   expected_outs [$];
    int                         errors;

    function new();
      min_gain = -16'sd15360;
      max_gain = 16'sd2560;
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_len[b] = '0;
        for (int t = 0; t < MAX_TAPS; t++) coef[b][t] = '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        wipe(c);
        active[c] = BANK_MID;
      end
      errors = 0;
    endfunction

    function void wipe(int c);
      for (int t = 0; t < MAX_TAPS; t++) hist[c][t] = '0;
      wr_pos[c] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_MIN_GAIN:  min_gain = val[GAIN_W-1:0];
        REG_MAX_GAIN:  max_gain = val[GAIN_W-1:0];
        REG_BANK0_LEN: bank_len[BANK_LOW] = val[LEN_W-1:0];
        REG_BANK1_LEN: bank_len[BANK_MID] = val[LEN_W-1:0];
        REG_BANK2_LEN: bank_len[BANK_HIGH] = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp the gain and split the min-max range in thirds
    function bank_t gain_bank(logic signed [GAIN_W-1:0] g);
      longint lo, hi, span, d, gg;
      lo = min_gain;
      hi = max_gain;
      gg = g;
      span = hi - lo;
      if (span <= 0) return BANK_LOW;
      if (gg < lo) gg = lo;
      if (gg > hi) gg = hi;
      d = gg - lo;
      if (3 * d < span) return BANK_LOW;
      if (3 * d < 2 * span) return BANK_MID;
      return BANK_HIGH;
    endfunction

    function fir_out_t filter_sample(beat_t b);
      fir_out_t r;
      bank_t    bk;
      int       taps;
      int       pos;
      int       idx;
      longint   acc;
      bk = gain_bank(b.fader_gain);
      taps = (bank_len[bk] > MAX_TAPS) ? MAX_TAPS : int'(bank_len[bk]);
      r.bank = bk;
      r.filtered = 1'b0;
      r.sample = b.sample_in;
      // Out-of-range channel or empty bank: pass through, no state change
      if (b.channel >= CHANNELS || taps == 0) return r;
      if (active[b.channel] != bk) begin
        wipe(b.channel);
        active[b.channel] = bk;
      end
      pos = wr_pos[b.channel];
      hist[b.channel][pos] = b.sample_in;
      acc = 0;
      idx = pos;
      for (int t = 0; t < taps; t++) begin
        acc += longint'(coef[bk][t]) * longint'(hist[b.channel][idx]);
        idx = (idx == 0) ? MAX_TAPS - 1 : idx - 1;
      end
      wr_pos[b.channel] = (pos + 1) % MAX_TAPS;
      // Round half up, then saturate to Q1.23
      acc = (acc + 64'sd32768) >>> FRAC_SHIFT;
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      r.sample = acc[SAMPLE_W-1:0];
      r.filtered = 1'b1;
      return r;
    endfunction

    function void note_beat(beat_t b);
      case (b.opcode)
        OP_FILTER: expected_outs = {expected_outs, filter_sample(b)};
        OP_COEF: begin
          if (b.coef_bank < NUM_BANKS && b.coef_index < MAX_TAPS)
            coef[b.coef_bank][b.coef_index] = b.coef_value;
        end
        OP_CLEAR: for (int c = 0; c < CHANNELS; c++) wipe(c);
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] s, logic [1:0] bk, logic f);
      fir_out_t e;
      if (expected_outs.size() == 0) begin
        $error("unexpected result beat: sample_out %0d bank_used %0d filtered %0b", s, bk, f);
        errors++;
        return;
      end
      e = expected_outs.pop_front();
      if (s !== e.sample) begin
        $error("sample_out: expected %0d, got %0d", e.sample, s);
        errors++;
      end
      if (bk !== e.bank) begin
        $error("bank_used: expected %0d, got %0d", e.bank, bk);
        errors++;
      end
      if (f !== e.filtered) begin
        $error("filtered: expected %0b, got %0b", e.filtered, f);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 opcode;
  logic [1:0]                 channel;
  logic signed [GAIN_W-1:0]   fader_gain;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [1:0]                 coef_bank;
  logic [CIDX_W-1:0]          coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [1:0]                 bank_used;
  logic                       filtered;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  fir_board sb = new();
  int send_gap_pct;
  int recv_stall_pct;
  int loaded [NUM_BANKS];

  fader_selected_fir_convolver #(
    .MAX_TAPS(MAX_TAPS),
    .CHANNELS(CHANNELS)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .channel(channel), .fader_gain(fader_gain), .sample_in(sample_in),
    .coef_bank(coef_bank), .coef_index(coef_index), .coef_value(coef_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_out(sample_out), .bank_used(bank_used), .filtered(filtered),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Take result beats and stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(sample_out, bank_used, filtered);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void set_pace(pace_t p);
    case (p)
      PACE_SEND_LIGHT: begin
        send_gap_pct = 33;
        recv_stall_pct = 69;
      end
      PACE_SEND_HEAVY: begin
        send_gap_pct = 69;
        recv_stall_pct = 33;
      end
      default: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.opcode = 2'($urandom);
    b.channel = 2'($urandom);
    b.fader_gain = GAIN_W'($urandom);
    b.sample_in = SAMPLE_W'($urandom);
    b.coef_bank = 2'($urandom);
    b.coef_index = CIDX_W'($urandom);
    b.coef_value = COEF_W'($urandom);
    return b;
  endfunction

  // Gains at the clamp limits, around the bank thresholds and at the ends of the 16-bit range
  function automatic logic signed [GAIN_W-1:0] border_gain();
    longint lo, hi, span, g;
    lo = sb.min_gain;
    hi = sb.max_gain;
    span = hi - lo;
    case ($urandom_range(5))
      0: g = lo;
      1: g = hi;
      2: g = lo + span / 3;
      3: g = lo + (2 * span) / 3;
      4: g = -32768;
      default: g = 32767;
    endcase
    g = g + longint'($urandom_range(4)) - 2;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    return g[GAIN_W-1:0];
  endfunction

  function automatic logic signed [GAIN_W-1:0] any_gain();
    if ($urandom_range(1) == 0) return GAIN_W'($urandom);
    return border_gain();
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_pick();
    int r;
    r = $urandom_range(99);
    if (r < 70) return SAMPLE_W'($urandom);
    if (r < 85) return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    return SAMPLE_W'(longint'($urandom_range(512)) - 256);
  endfunction

  // Mostly small coefficients so sums stay away from saturation
  function automatic logic signed [COEF_W-1:0] coef_pick();
    int r;
    r = $urandom_range(99);
    if (r < 70) return COEF_W'(longint'($urandom_range(16384)) - 8192);
    if (r < 90) return COEF_W'($urandom);
    return $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
  endfunction

  // Hold each beat until taken; valid drops only across a gap
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= b.opcode;
    channel    <= b.channel;
    fader_gain <= b.fader_gain;
    sample_in  <= b.sample_in;
    coef_bank  <= b.coef_bank;
    coef_index <= b.coef_index;
    coef_value <= b.coef_value;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
  endtask

  task automatic send_filter(input logic [1:0] ch, input logic signed [GAIN_W-1:0] g,
                             input logic signed [SAMPLE_W-1:0] s);
    beat_t b;
    b = noise_beat();
    b.opcode = OP_FILTER;
    b.channel = ch;
    b.fader_gain = g;
    b.sample_in = s;
    send_beat(b);
  endtask

  task automatic send_coef(input logic [1:0] bk, input logic [CIDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] v);
    beat_t b;
    b = noise_beat();
    b.opcode = OP_COEF;
    b.coef_bank = bk;
    b.coef_index = idx;
    b.coef_value = v;
    send_beat(b);
  endtask

  task automatic send_op(input logic [1:0] op);
    beat_t b;
    b = noise_beat();
    b.opcode = op;
    send_beat(b);
  endtask

  // Fill a bank's taps from the first never-written one up to count
  task automatic load_bank(input logic [1:0] bk, input int count);
    for (int i = loaded[bk]; i < count; i++) send_coef(bk, CIDX_W'(i), coef_pick());
    if (count > loaded[bk]) loaded[bk] = count;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_outs.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for the block to go idle, then rewrite every register
  task automatic apply_setting(input logic signed [GAIN_W-1:0] lo,
                               input logic signed [GAIN_W-1:0] hi,
                               input int len0, input int len1, input int len2);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MIN_GAIN, {lo});
    write_reg(REG_MAX_GAIN, {hi});
    write_reg(REG_BANK0_LEN, len0);
    write_reg(REG_BANK1_LEN, len1);
    write_reg(REG_BANK2_LEN, len2);
  endtask

  // Random beats: mostly samples with a held gain per channel so history builds up
  task automatic random_run(input int count);
    beat_t                    b;
    int                       n;
    int                       r;
    int                       bk;
    logic signed [GAIN_W-1:0] held [4];
    for (int c = 0; c < 4; c++) held[c] = any_gain();
    n = 0;
    while (n < count) begin
      b = noise_beat();
      r = $urandom_range(99);
      if (r < 78) begin
        b.opcode = OP_FILTER;
        b.channel = 2'(($urandom_range(99) < 85) ? $urandom_range(1) : $urandom_range(3, 2));
        if ($urandom_range(99) < 5) held[b.channel] = any_gain();
        b.fader_gain = ($urandom_range(99) < 75) ? held[b.channel] : any_gain();
        b.sample_in = sample_pick();
      end else if (r < 92) begin
        b.opcode = OP_COEF;
        if ($urandom_range(99) < 70) begin
          bk = $urandom_range(NUM_BANKS - 1);
          b.coef_bank = 2'(bk);
          b.coef_index = CIDX_W'($urandom_range(loaded[bk] - 1));
        end
        b.coef_value = coef_pick();
      end else if (r < 96) begin
        b.opcode = OP_CLEAR;
      end else begin
        b.opcode = OP_UNUSED;
      end
      if (n == count / 2 || $urandom_range(99) < 2) drain_results();
      send_beat(b);
      if (!(b.opcode == OP_UNUSED || (b.opcode == OP_COEF && b.coef_bank >= NUM_BANKS)))
        n++;
    end
  endtask

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    opcode     <= OP_FILTER;
    channel    <= '0;
    fader_gain <= '0;
    sample_in  <= '0;
    coef_bank  <= BANK_LOW;
    coef_index <= '0;
    coef_value <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    for (int b = 0; b < NUM_BANKS; b++) loaded[b] = 0;
    set_pace(PACE_SEND_LIGHT);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset lengths are zero: everything passes through
    send_filter(0, -32768, 24'sh800000);
    send_filter(1, 32767, 24'sh7FFFFF);
    send_filter(3, 0, sample_pick());
    send_filter(2, -7360, sample_pick());
    send_op(OP_UNUSED);
    send_coef(BANK_NONE, 1023, 18'sh20000);
    send_op(OP_CLEAR);

    for (int b = 0; b < NUM_BANKS; b++) load_bank(2'(b), PRELOAD_TAPS);
    apply_setting(-15360, 2560, 3, 5, 8);

    // Full-scale taps drive the sum into both saturation limits
    for (int i = 0; i < 3; i++) send_coef(BANK_LOW, CIDX_W'(i), 18'sh1FFFF);
    repeat (3) send_filter(0, -15360, 24'sh7FFFFF);
    repeat (2) send_filter(0, -15360, 24'sh800000);
    // Exact halves round toward positive infinity
    send_coef(BANK_MID, 0, 18'sd32768);
    send_op(OP_CLEAR);
    send_filter(1, -7360, 24'sd1);
    send_op(OP_CLEAR);
    send_filter(1, -7360, -24'sd1);
    send_coef(BANK_HIGH, 1023, 18'sh1FFFF);

    random_run(RUN_LEN);
    apply_setting(-32768, 32767, 1, 12, 0);
    random_run(RUN_LEN);
    set_pace(PACE_SEND_HEAVY);
    // Reversed and zero ranges always pick the low bank
    apply_setting(32767, -32768, 24, 12, 0);
    random_run(RUN_LEN);
    apply_setting(100, 100, 0, 6, 17);
    random_run(RUN_LEN);
    set_pace(PACE_NONE);
    apply_setting(-256, 512, 20, 2, 9);
    random_run(RUN_LEN);
    apply_setting(-15360, 2560, 7, 24, 1);
    random_run(RUN_LEN);

    // Longest filter: oversized length acts as the full tap count
    load_bank(BANK_HIGH, MAX_TAPS);
    apply_setting(-15360, 2560, 7, 24, 2047);
    repeat (4) send_filter(0, 2560, sample_pick());
    apply_setting(-15360, 2560, 7, 24, MAX_TAPS);
    repeat (2) send_filter(0, 32767, sample_pick());

    // Run one channel past the end of its circular history
    apply_setting(-15360, 2560, 0, 2, 0);
    repeat (MAX_TAPS + 16) send_filter(1, -7360, sample_pick());

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fsfc_pkg.sv
rtl/fsfc_mac.sv
rtl/fader_selected_fir_convolver.sv
test/tb.sv
